// ===== src/vsmc_pkg.sv =====
// shared types, codes and reset values for the valve selection mode controller
// no dependencies
package vsmc_pkg;

    // mode codes
    typedef enum logic [2:0] {
        MODE_WAIT    = 3'd0,
        MODE_HYST    = 3'd1,
        MODE_STAB    = 3'd2,
        MODE_TARGET  = 3'd3,
        MODE_COUNT   = 3'd4,
        MODE_TAKEOFF = 3'd5
    } mode_t;

    // button event codes
    localparam logic [1:0] BTN_NONE  = 2'd0;
    localparam logic [1:0] BTN_SHORT = 2'd1;
    localparam logic [1:0] BTN_LONG  = 2'd2;

    // register indexes on the configuration port
    localparam logic [2:0] REG_HYST_STEP    = 3'd0;
    localparam logic [2:0] REG_HYST_MAX     = 3'd1;
    localparam logic [2:0] REG_TARGET_MIN   = 3'd2;
    localparam logic [2:0] REG_TARGET_MAX   = 3'd3;
    localparam logic [2:0] REG_TARGET_STEP  = 3'd4;
    localparam logic [2:0] REG_STAB_MINUTES = 3'd5;
    localparam logic [2:0] REG_STAB_SECONDS = 3'd6;

    localparam int CFG_ADDR_W = 5;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;

    // seconds reload on minute borrow
    localparam logic [5:0] SECONDS_WRAP = 6'd59;

    typedef struct packed {
        logic [4:0]  hyst_step;
        logic [6:0]  hyst_max;
        logic [10:0] target_min;
        logic [10:0] target_max;
        logic [7:0]  target_step;
        logic [5:0]  stab_minutes;
        logic [5:0]  stab_seconds;
    } cfg_t;

    typedef struct packed {
        mode_t              mode;
        logic               valve;
        logic [6:0]         hyst;
        logic [10:0]        target;
        logic signed [11:0] latched;
        logic [5:0]         minutes;
        logic [5:0]         seconds;
        logic               started;
    } state_t;

    localparam cfg_t CFG_RESET = '{
        hyst_step:    5'd8,
        hyst_max:     7'd48,
        target_min:   11'd480,
        target_max:   11'd560,
        target_step:  8'd16,
        stab_minutes: 6'd0,
        stab_seconds: 6'd20
    };

    localparam state_t STATE_RESET = '{
        mode:    MODE_WAIT,
        valve:   1'b0,
        hyst:    7'd8,
        target:  11'd480,
        latched: 12'sd0,
        minutes: 6'd5,
        seconds: 6'd0,
        started: 1'b0
    };

endpackage

// ===== src/vsmc_cfg.sv =====
// apb register file holding the seven controller settings
// depends on vsmc_pkg
module vsmc_cfg
    import vsmc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_HYST_STEP:    cfg_reg.hyst_step    <= pwdata[4:0];
                REG_HYST_MAX:     cfg_reg.hyst_max     <= pwdata[6:0];
                REG_TARGET_MIN:   cfg_reg.target_min   <= pwdata[10:0];
                REG_TARGET_MAX:   cfg_reg.target_max   <= pwdata[10:0];
                REG_TARGET_STEP:  cfg_reg.target_step  <= pwdata[7:0];
                REG_STAB_MINUTES: cfg_reg.stab_minutes <= pwdata[5:0];
                REG_STAB_SECONDS: cfg_reg.stab_seconds <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    // register read mux
    always_comb begin
        unique case (reg_idx)
            REG_HYST_STEP:    prdata = {27'd0, cfg_reg.hyst_step};
            REG_HYST_MAX:     prdata = {25'd0, cfg_reg.hyst_max};
            REG_TARGET_MIN:   prdata = {21'd0, cfg_reg.target_min};
            REG_TARGET_MAX:   prdata = {21'd0, cfg_reg.target_max};
            REG_TARGET_STEP:  prdata = {24'd0, cfg_reg.target_step};
            REG_STAB_MINUTES: prdata = {26'd0, cfg_reg.stab_minutes};
            REG_STAB_SECONDS: prdata = {26'd0, cfg_reg.stab_seconds};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

// ===== src/vsmc_step.sv =====
// next-state logic for one control step: mode changes, setup wraps,
// countdown and valve decision; depends on vsmc_pkg
module vsmc_step
    import vsmc_pkg::*;
(
    input  state_t             cur,
    input  cfg_t               cfg,
    input  logic signed [11:0] temperature,
    input  logic [1:0]         button,
    input  logic               second_tick,
    output state_t             nxt
);

    logic [7:0]         hyst_sum;
    logic [11:0]        target_sum;
    logic signed [12:0] temp_ext;
    logic signed [12:0] target_ext;
    logic signed [12:0] valve_limit;
    logic               is_short;
    logic               is_long;

    // shared adders and compares
    assign hyst_sum    = {1'b0, cur.hyst} + {3'd0, cfg.hyst_step};
    assign target_sum  = {1'b0, cur.target} + {4'd0, cfg.target_step};
    assign temp_ext    = {temperature[11], temperature};
    assign target_ext  = {2'b00, cur.target};
    assign valve_limit = {cur.latched[11], cur.latched} + $signed({6'd0, cur.hyst});
    assign is_short    = (button == BTN_SHORT);
    assign is_long     = (button == BTN_LONG);

    always_comb begin
        nxt = cur;
        unique case (cur.mode)
            MODE_HYST: begin
                if (is_short) begin
                    if (hyst_sum > {1'b0, cfg.hyst_max}) begin
                        nxt.hyst = {2'd0, cfg.hyst_step};
                    end else begin
                        nxt.hyst = hyst_sum[6:0];
                    end
                end else if (is_long) begin
                    nxt.mode = MODE_WAIT;
                end
            end
            MODE_STAB: begin
                // temperature check beats a long hold
                if (temp_ext >= target_ext) begin
                    nxt.mode = MODE_COUNT;
                end else if (is_long) begin
                    nxt.mode = MODE_TARGET;
                end
            end
            MODE_TARGET: begin
                if (is_short) begin
                    if (target_sum > {1'b0, cfg.target_max}) begin
                        nxt.target = cfg.target_min;
                    end else begin
                        nxt.target = target_sum[10:0];
                    end
                end else if (is_long) begin
                    nxt.mode = MODE_STAB;
                end
            end
            MODE_COUNT: begin
                // first step loads presets, later ticks count down
                if (!cur.started) begin
                    nxt.minutes = cfg.stab_minutes;
                    nxt.seconds = cfg.stab_seconds;
                    nxt.started = 1'b1;
                end else if (second_tick) begin
                    if (cur.seconds != 6'd0) begin
                        nxt.seconds = cur.seconds - 6'd1;
                    end else if (cur.minutes != 6'd0) begin
                        nxt.seconds = SECONDS_WRAP;
                        nxt.minutes = cur.minutes - 6'd1;
                    end else begin
                        nxt.started = 1'b0;
                        nxt.latched = temperature;
                        nxt.mode    = MODE_TAKEOFF;
                    end
                end
            end
            MODE_TAKEOFF: begin
                if (is_long) begin
                    nxt.valve   = 1'b0;
                    nxt.latched = 12'sd0;
                    nxt.mode    = MODE_WAIT;
                end else begin
                    nxt.valve = (temp_ext <= valve_limit);
                end
            end
            default: begin
                // wait, and any stray code
                if (is_long) begin
                    nxt.mode = MODE_HYST;
                end else if (is_short) begin
                    nxt.mode = MODE_STAB;
                end
            end
        endcase
    end

endmodule

// ===== src/valve_selection_mode_controller.sv =====
// top level of the valve selection mode controller: input register, state
// registers, result register; depends on vsmc_pkg, vsmc_cfg, vsmc_step
//
//  port group  | dir | payload (lsb first)
//  s_axis      | in  | temperature[11:0], button[13:12], second_tick[14]
//  m_axis      | out | mode, valve_open, hysteresis, target, latched_temp,
//              |     | count_minutes, count_seconds
//  apb         | in  | seven settings at byte addresses 0..24
//
// one item per clock sustained while m_axis is not stalled; the path from input
// to result runs through the input register, then step logic into the result register
// the step logic and controller state advance only when the result register
// can take the new result; a stall on m_axis backs up through the input
// register to s_tready
// reset is synchronous active low and restores settings and state
module valve_selection_mode_controller
    import vsmc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // temperature, button, second_tick
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // mode, valve_open, hysteresis,
                                             // target, latched_temp,
                                             // count_minutes, count_seconds
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t               cfg;
    state_t             state_reg;
    state_t             state_next;
    logic               in_valid_reg;
    logic signed [11:0] temp_reg;
    logic [1:0]         button_reg;
    logic               tick_reg;
    logic               out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic               advance;
    logic               s_fire;

    vsmc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vsmc_step u_step (
        .cur         (state_reg),
        .cfg         (cfg),
        .temperature (temp_reg),
        .button      (button_reg),
        .second_tick (tick_reg),
        .nxt         (state_next)
    );

    // handshake
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            temp_reg   <= s_tdata[11:0];
            button_reg <= s_tdata[13:12];
            tick_reg   <= s_tdata[14];
        end
    end

    // controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (in_valid_reg && advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && advance) begin
            out_data_reg <= {2'b00,
                             state_next.seconds,
                             state_next.minutes,
                             state_next.latched,
                             state_next.target,
                             state_next.hyst,
                             state_next.valve,
                             state_next.mode};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // valve can only be open in take-off
    a_valve_in_takeoff: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.valve |-> (state_reg.mode == MODE_TAKEOFF))
        else $error("valve open outside take-off");

    // countdown flag lives only in countdown mode
    a_started_in_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.started |-> (state_reg.mode == MODE_COUNT))
        else $error("countdown flag set outside countdown");

    // latch is cleared whenever take-off is not active
    a_latch_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.latched != 12'sd0) |-> (state_reg.mode == MODE_TAKEOFF))
        else $error("latched temperature held outside take-off");

    // a stalled input item is not dropped
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pending input item lost while stalled");

    // state does not move without a step being taken
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_valid_reg && advance) |=> $stable(state_reg))
        else $error("controller state changed without an item");

endmodule

// ===== tb/tb.sv =====
// self-checking bench for valve_selection_mode_controller: a shadow of the
// controller predicts every result item, the stream and apb ports are driven
// by plain tasks; depends on vsmc_pkg and the controller rtl
module tb;
    import vsmc_pkg::*;

    // button code three carries no event
    localparam logic [1:0] BTN_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 230;

    // result item layout, lowest field last
    typedef struct packed {
        logic [1:0]  pad;
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [11:0] latched;
        logic [10:0] target;
        logic [6:0]  hyst;
        logic        valve;
        logic [2:0]  mode;
    } result_t;

    // shadow of the controller: settings, state and the results still due
    class mode_tracker;
        int unsigned hyst_step, hyst_max, target_min, target_max, target_step;
        int unsigned stab_minutes, stab_seconds;
        mode_t       mode;
        bit          valve;
        bit          started;
        int unsigned hyst, target, minutes, seconds;
        int          latched;
        result_t     step_queue[$];
        int          failures;

        function new();
            hyst_step    = CFG_RESET.hyst_step;
            hyst_max     = CFG_RESET.hyst_max;
            target_min   = CFG_RESET.target_min;
            target_max   = CFG_RESET.target_max;
            target_step  = CFG_RESET.target_step;
            stab_minutes = CFG_RESET.stab_minutes;
            stab_seconds = CFG_RESET.stab_seconds;
            mode         = STATE_RESET.mode;
            valve        = STATE_RESET.valve;
            hyst         = STATE_RESET.hyst;
            target       = STATE_RESET.target;
            latched      = STATE_RESET.latched;
            minutes      = STATE_RESET.minutes;
            seconds      = STATE_RESET.seconds;
            started      = STATE_RESET.started;
            failures     = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_HYST_STEP:    hyst_step    = v[4:0];
                REG_HYST_MAX:     hyst_max     = v[6:0];
                REG_TARGET_MIN:   target_min   = v[10:0];
                REG_TARGET_MAX:   target_max   = v[10:0];
                REG_TARGET_STEP:  target_step  = v[7:0];
                REG_STAB_MINUTES: stab_minutes = v[5:0];
                REG_STAB_SECONDS: stab_seconds = v[5:0];
                default: ;
            endcase
        endfunction

        // one control step for an accepted item
        function void note_step(logic [11:0] temp, logic [1:0] btn, logic tick);
            int          t;
            int unsigned sum;
            result_t     r;
            t = int'($signed(temp));
            case (mode)
                MODE_HYST: begin
                    if (btn == BTN_SHORT) begin
                        sum = hyst + hyst_step;
                        hyst = (sum > hyst_max) ? hyst_step : sum;
                    end else if (btn == BTN_LONG) begin
                        mode = MODE_WAIT;
                    end
                end
                MODE_STAB: begin
                    // reaching target beats a long hold
                    if (btn == BTN_LONG) mode = MODE_TARGET;
                    if (t >= int'(target)) mode = MODE_COUNT;
                end
                MODE_TARGET: begin
                    if (btn == BTN_SHORT) begin
                        sum = target + target_step;
                        target = (sum > target_max) ? target_min : sum;
                    end else if (btn == BTN_LONG) begin
                        mode = MODE_STAB;
                    end
                end
                MODE_COUNT: begin
                    if (!started) begin
                        minutes = stab_minutes;
                        seconds = stab_seconds;
                        started = 1'b1;
                    end else if (tick) begin
                        if (seconds > 0) begin
                            seconds--;
                        end else if (minutes > 0) begin
                            seconds = SECONDS_WRAP;
                            minutes--;
                        end else begin
                            started = 1'b0;
                            latched = t;
                            mode = MODE_TAKEOFF;
                        end
                    end
                end
                MODE_TAKEOFF: begin
                    valve = (t <= latched + int'(hyst));
                    if (btn == BTN_LONG) begin
                        valve = 1'b0;
                        latched = 0;
                        mode = MODE_WAIT;
                    end
                end
                default: begin
                    if (btn == BTN_LONG) mode = MODE_HYST;
                    else if (btn == BTN_SHORT) mode = MODE_STAB;
                end
            endcase
            r.pad     = '0;
            r.mode    = mode;
            r.valve   = valve;
            r.hyst    = hyst[6:0];
            r.target  = target[10:0];
            r.latched = latched[11:0];
            r.minutes = minutes[5:0];
            r.seconds = seconds[5:0];
            step_queue.push_back(r);
        endfunction

        function void cmp(string name, logic [11:0] want, logic [11:0] got);
            if (got !== want) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch in %s: expected %0h, got %0h", name, want, got);
            end
        endfunction

        function void check_output(logic [OUT_DATA_W-1:0] data);
            result_t got, want;
            got = data;
            if (step_queue.size() == 0) begin
                failures++;
                if (failures <= 10) $display("result item with none due: %h", data);
                return;
            end
            want = step_queue.pop_front();
            cmp("mode", 12'(want.mode), 12'(got.mode));
            cmp("valve_open", 12'(want.valve), 12'(got.valve));
            cmp("hysteresis", 12'(want.hyst), 12'(got.hyst));
            cmp("target", 12'(want.target), 12'(got.target));
            cmp("latched_temp", want.latched, got.latched);
            cmp("count_minutes", 12'(want.minutes), 12'(got.minutes));
            cmp("count_seconds", 12'(want.seconds), 12'(got.seconds));
        endfunction

        function int pending();
            return step_queue.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // temperature, button, second_tick
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // mode, valve_open, hysteresis,
                                            // target, latched_temp,
                                            // count_minutes, count_seconds
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    mode_tracker tracker = new();
    bit          calm = 1'b0;
    int          stall_left = 0;
    int          quiet = 0;

    valve_selection_mode_controller dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: check accepted items, stall in random bursts
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_output(m_tdata);
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (!calm && $urandom_range(0, 19) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 14);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= QUIET_LIMIT) begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    function automatic logic [11:0] clamp12(int v);
        if (v > 2047) v = 2047;
        if (v < -2048) v = -2048;
        return v[11:0];
    endfunction

    // send one item, optionally after an idle burst
    task automatic send_item(logic [11:0] temp, logic [1:0] btn, logic tick);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, tick, btn, temp};
        do @(posedge aclk); while (!s_tready);
        tracker.note_step(temp, btn, tick);
    endtask

    // stop sending and let every due result come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // write all seven settings over apb
    task automatic apply_settings(int hs, int hm, int tmin, int tmax, int ts,
                                  int sm, int ss);
        logic [31:0] vals [7];
        vals = '{hs, hm, tmin, tmax, ts, sm, ss};
        for (int i = 0; i < 7; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= CFG_ADDR_W'(4 * i);
            pwdata  <= vals[i];
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            tracker.set_reg(3'(i), vals[i]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // random item shaped by the predicted mode, with some noise
    task automatic next_item(output logic [11:0] temp, output logic [1:0] btn,
                             output logic tick);
        int r;
        r    = $urandom_range(0, 9);
        temp = 12'($urandom);
        btn  = 2'($urandom);
        tick = 1'($urandom);
        if ($urandom_range(0, 99) >= 12) begin
            case (tracker.mode)
                MODE_WAIT:
                    btn = (r < 5) ? BTN_SHORT : (r < 8) ? BTN_LONG : BTN_NONE;
                MODE_HYST, MODE_TARGET:
                    btn = (r < 6) ? BTN_SHORT : (r < 8) ? BTN_LONG :
                          (r < 9) ? BTN_NONE : BTN_UNUSED;
                MODE_STAB: begin
                    // hover around the target so it is reached after a few steps
                    temp = clamp12(int'(tracker.target) + int'($urandom_range(0, 40)) - 30);
                    btn  = (r < 2) ? BTN_LONG : (r < 6) ? BTN_NONE : BTN_SHORT;
                end
                MODE_COUNT:
                    tick = ($urandom_range(0, 9) < 8);
                MODE_TAKEOFF: begin
                    // straddle the valve threshold
                    temp = clamp12(tracker.latched + int'(tracker.hyst)
                                   + int'($urandom_range(0, 6)) - 3);
                    btn  = (r < 1) ? BTN_LONG : (r < 6) ? BTN_NONE : BTN_SHORT;
                end
                default: ;
            endcase
        end
    endtask

    initial begin
        logic [11:0] temp;
        logic [1:0]  btn;
        logic        tick;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // short countdown preset for the directed run
        apply_settings(8, 48, 480, 560, 16, 0, 1);

        // directed: wait, hysteresis wrap, target steps, stabilization entry and exit
        send_item(12'h800, BTN_UNUSED, 1'b1);
        send_item(12'h7ff, BTN_NONE, 1'b0);
        send_item(12'd100, BTN_LONG, 1'b0);
        repeat (6) send_item(12'd100, BTN_SHORT, 1'b0);
        send_item(12'd100, BTN_UNUSED, 1'b0);
        send_item(12'd100, BTN_LONG, 1'b0);
        send_item(12'd100, BTN_SHORT, 1'b0);
        send_item(12'd100, BTN_LONG, 1'b0);
        repeat (2) send_item(12'd100, BTN_SHORT, 1'b0);
        send_item(12'd100, BTN_LONG, 1'b0);
        send_item(12'd480, BTN_LONG, 1'b0);
        send_item(12'd300, BTN_SHORT, 1'b1);
        send_item(12'd300, BTN_LONG, 1'b0);
        send_item(12'd300, BTN_NONE, 1'b1);
        send_item(12'd500, BTN_NONE, 1'b1);
        send_item(12'd508, BTN_NONE, 1'b0);
        send_item(12'd509, BTN_SHORT, 1'b0);
        send_item(12'h800, BTN_NONE, 1'b0);
        send_item(12'd0, BTN_LONG, 1'b0);

        // random phases, each under its own settings
        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: apply_settings(8, 48, 480, 560, 16, 0, 20);
                1: apply_settings(0, 0, 0, 0, 0, 0, 0);
                2: apply_settings(31, 127, 2047, 2047, 255, 0, 63);
                3: apply_settings(16, 64, 0, 2000, 160, 1, 59);
                4: apply_settings(1, 1, 2000, 0, 1, 0, 0);
                default:
                    apply_settings($urandom_range(0, 31), $urandom_range(0, 127),
                                   $urandom_range(0, 2047), $urandom_range(0, 2047),
                                   $urandom_range(0, 255), $urandom_range(0, 1),
                                   $urandom_range(0, 12));
            endcase
            if (p == PHASES - 1) calm = 1'b1;
            repeat (PHASE_ITEMS) begin
                next_item(temp, btn, tick);
                send_item(temp, btn, tick);
            end
        end

        // wind down and report
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (tracker.pending() != 0) tracker.failures++;
        if (tracker.failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/vsmc_pkg.sv
src/vsmc_cfg.sv
src/vsmc_step.sv
src/valve_selection_mode_controller.sv
tb/tb.sv
